### rtl/core/pgmq_pkg.sv
// ----------------------------------------------------------------------------
// pgmq_pkg
// Shared widths, codes, payload structures and the gamut coefficient table
// for the premultiplied gamut, matte and quantize pipeline.
// ----------------------------------------------------------------------------
package pgmq_pkg;

	// Fixed-point formats.
	localparam int SampleFracBits = 16;
	localparam int CoefFracBits   = 18;
	localparam int HiFracBits     = (CoefFracBits > SampleFracBits) ? CoefFracBits
	                                                                : SampleFracBits;
	localparam int TotFrac        = SampleFracBits + HiFracBits;
	localparam int MatteShift     = HiFracBits - SampleFracBits;

	// Field widths.
	localparam int SampleW  = 24;
	localparam int AlphaW   = 17;
	localparam int CoefW    = 20;
	localparam int OutW     = 16;
	localparam int StatusW  = 2;
	localparam int ProdW    = SampleW + CoefW;
	localparam int MatteProdW = SampleW + AlphaW + 1;
	localparam int TotW     = ProdW + 2;
	localparam int ScaledW  = TotFrac + OutW;

	localparam int AlphaOne = 1 << SampleFracBits;
	localparam int CoefOne  = 1 << CoefFracBits;

	// Port widths.
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 24;
	localparam int InFieldsW = 3 * SampleW + AlphaW;
	localparam int InDataW   = ((InFieldsW + 7) / 8) * 8;
	localparam int OutFieldsW = 3 * OutW + StatusW;
	localparam int OutDataW  = ((OutFieldsW + 7) / 8) * 8;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic signed [CoefW-1:0]   coef_t;
	typedef logic signed [ProdW-1:0]   prod_t;
	typedef logic signed [TotW-1:0]    total_t;
	typedef logic [OutW-1:0]           chan_t;

	typedef enum logic {
		ENC_SRGB   = 1'b0,
		ENC_BT2020 = 1'b1
	} encoding_t;

	typedef enum logic [1:0] {
		MODE_IDENTITY,
		MODE_SRGB_TO_BT2020,
		MODE_BT2020_TO_SRGB
	} gamut_mode_t;

	typedef enum logic [StatusW-1:0] {
		STATUS_OK         = 2'd0,
		STATUS_ALPHA_HIGH = 2'd1,
		STATUS_ZERO_ALPHA = 2'd2
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SOURCE_ENCODING      = 3'd0,
		REG_DESTINATION_ENCODING = 3'd1,
		REG_MATTE_RED            = 3'd2,
		REG_MATTE_GREEN          = 3'd3,
		REG_MATTE_BLUE           = 3'd4
	} reg_index_t;

	typedef struct packed {
		sample_t [2:0]     rgb;
		logic [AlphaW-1:0] alpha;
		status_t           status;
	} pixel_t;

	typedef struct packed {
		prod_t [8:0] prod;
		prod_t [2:0] matte;
		status_t     status;
	} prod_bus_t;

	typedef struct packed {
		total_t [2:0] total;
		status_t      status;
	} total_bus_t;

	typedef struct packed {
		chan_t [2:0] chan;
		status_t     status;
	} result_t;

	// Matrix entries in row-major order, rounded to CoefFracBits fraction bits.
	function automatic coef_t gamut_coef(input gamut_mode_t mode, input logic [3:0] idx);
		coef_t c;
		begin
			c = '0;
			case (mode)
				MODE_SRGB_TO_BT2020: begin
					case (idx)
						4'd0:    c = 20'sd164470;
						4'd1:    c = 20'sd86320;
						4'd2:    c = 20'sd11354;
						4'd3:    c = 20'sd18113;
						4'd4:    c = 20'sd241052;
						4'd5:    c = 20'sd2979;
						4'd6:    c = 20'sd4297;
						4'd7:    c = 20'sd23072;
						4'd8:    c = 20'sd234775;
						default: c = '0;
					endcase
				end
				MODE_BT2020_TO_SRGB: begin
					case (idx)
						4'd0:    c = 20'sd435288;
						4'd1:    c = -20'sd154047;
						4'd2:    c = -20'sd19097;
						4'd3:    c = -20'sd32650;
						4'd4:    c = 20'sd296983;
						4'd5:    c = -20'sd2189;
						4'd6:    c = -20'sd4758;
						4'd7:    c = -20'sd26366;
						4'd8:    c = 20'sd293268;
						default: c = '0;
					endcase
				end
				default: begin
					if (idx == 4'd0 || idx == 4'd4 || idx == 4'd8) begin
						c = CoefW'(CoefOne);
					end else begin
						c = '0;
					end
				end
			endcase
			return c;
		end
	endfunction

endpackage

### rtl/core/pgmq_mult.sv
// ----------------------------------------------------------------------------
// pgmq_mult
// Multiplier stage: nine matrix products and three matte products per pixel,
// held in one pipeline register.
// ----------------------------------------------------------------------------
module pgmq_mult (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  pgmq_pkg::pixel_t         in_pixel,
	input  pgmq_pkg::gamut_mode_t    mode,
	input  pgmq_pkg::sample_t [2:0]  matte,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pgmq_pkg::prod_bus_t      out_bus
);

	logic                                 valid_s2;
	pgmq_pkg::prod_bus_t                  bus_s2;
	pgmq_pkg::prod_bus_t                  prod_d;
	logic [pgmq_pkg::AlphaW-1:0]          inv_alpha;
	logic signed [pgmq_pkg::MatteProdW-1:0] matte_prod [3];

	// One minus alpha; wraps harmlessly when alpha is out of range, as the
	// result is then forced to zero further down.
	assign inv_alpha = pgmq_pkg::AlphaW'(pgmq_pkg::AlphaOne) - in_pixel.alpha;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				prod_d.prod[3*k+j] = $signed(pgmq_pkg::gamut_coef(mode, 4'(3*k+j)))
				                     * $signed(in_pixel.rgb[j]);
			end
			matte_prod[k]   = $signed({1'b0, inv_alpha}) * $signed(matte[k]);
			prod_d.matte[k] = pgmq_pkg::prod_t'(matte_prod[k]) <<< pgmq_pkg::MatteShift;
		end
		prod_d.status = in_pixel.status;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bus_s2 <= prod_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_bus   = bus_s2;

endmodule

### rtl/core/pgmq_quant.sv
// ----------------------------------------------------------------------------
// pgmq_quant
// Sums the products of each channel, then clamps and rounds the sum to a
// 16-bit code in the result register.
// ----------------------------------------------------------------------------
module pgmq_quant (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pgmq_pkg::prod_bus_t   in_bus,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pgmq_pkg::result_t     out_result
);

	logic                   valid_s3;
	logic                   valid_s4;
	logic                   ready_s4;
	pgmq_pkg::total_bus_t   total_d;
	pgmq_pkg::total_bus_t   total_s3;
	pgmq_pkg::result_t      result_d;
	pgmq_pkg::result_t      result_s4;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			total_d.total[k] = pgmq_pkg::total_t'(in_bus.prod[3*k])
			                 + pgmq_pkg::total_t'(in_bus.prod[3*k+1])
			                 + pgmq_pkg::total_t'(in_bus.prod[3*k+2])
			                 + pgmq_pkg::total_t'(in_bus.matte[k]);
		end
		total_d.status = in_bus.status;
	end

	// The sum carries TotFrac fraction bits. The rounded code is
	// (v * 65535 + half) >> TotFrac, with v * 65535 formed as a shift and subtract.
	always_comb begin
		pgmq_pkg::total_t                v;
		logic [pgmq_pkg::TotFrac-1:0]    frac;
		logic [pgmq_pkg::ScaledW-1:0]    scaled;
		for (int k = 0; k < 3; k++) begin
			v      = total_s3.total[k];
			frac   = v[pgmq_pkg::TotFrac-1:0];
			scaled = {frac, {pgmq_pkg::OutW{1'b0}}}
			       - pgmq_pkg::ScaledW'(frac)
			       + (pgmq_pkg::ScaledW'(1) << (pgmq_pkg::TotFrac - 1));
			if (total_s3.status != pgmq_pkg::STATUS_OK) begin
				result_d.chan[k] = '0;
			end else if (v[pgmq_pkg::TotW-1] || v == '0) begin
				result_d.chan[k] = '0;
			end else if (|v[pgmq_pkg::TotW-2:pgmq_pkg::TotFrac]) begin
				result_d.chan[k] = '1;
			end else begin
				result_d.chan[k] = scaled[pgmq_pkg::ScaledW-1:pgmq_pkg::TotFrac];
			end
		end
		result_d.status = total_s3.status;
	end

	assign ready_s4 = !valid_s4 || out_ready;
	assign in_ready = !valid_s3 || ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			total_s3 <= total_d;
		end
		if (valid_s3 && ready_s4) begin
			result_s4 <= result_d;
		end
	end

	assign out_valid  = valid_s4;
	assign out_result = result_s4;

endmodule

### rtl/core/premultiplied_gamut_matte_quantize.sv
// ----------------------------------------------------------------------------
// premultiplied_gamut_matte_quantize
// Premultiplied linear RGBA to opaque 16-bit RGB with gamut matrix and matte.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output is not held back,
// through a four-stage pipeline: the input register (where the alpha
// checks are made), the multiplier register, the channel sum register and
// the quantized result register. Each stage stalls only when the stage
// after it is full, so bubbles close up while the output is held back. The
// matrix comes from the two encoding registers and the matte colour from the
// matte registers; these are read live by the pipeline and should be
// written only while no pixel is in flight.
module premultiplied_gamut_matte_quantize (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_wen,
	input  logic [pgmq_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [pgmq_pkg::CfgDataW-1:0]   cfg_data,
	// Pixel input.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// red[23:0], green[47:24], blue[71:48], alpha[88:72], zero padding above.
	input  logic [pgmq_pkg::InDataW-1:0]    s_axis_tdata,
	// Result output.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// out_red[15:0], out_green[31:16], out_blue[47:32], status[49:48], zero padding above.
	output logic [pgmq_pkg::OutDataW-1:0]   m_axis_tdata
);

	pgmq_pkg::encoding_t        source_encoding_q;
	pgmq_pkg::encoding_t        destination_encoding_q;
	pgmq_pkg::sample_t [2:0]    matte_q;
	pgmq_pkg::gamut_mode_t      mode;

	pgmq_pkg::pixel_t           pixel_d;
	pgmq_pkg::pixel_t           pixel_s1;
	logic                       valid_s1;
	logic                       mult_ready;
	logic                       mult_valid;
	pgmq_pkg::prod_bus_t        mult_bus;
	logic                       quant_ready;
	pgmq_pkg::result_t          result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_encoding_q      <= pgmq_pkg::ENC_SRGB;
			destination_encoding_q <= pgmq_pkg::ENC_SRGB;
			matte_q                <= '0;
		end else if (cfg_wen) begin
			case (pgmq_pkg::reg_index_t'(cfg_index))
				pgmq_pkg::REG_SOURCE_ENCODING:
					source_encoding_q <= pgmq_pkg::encoding_t'(cfg_data[0]);
				pgmq_pkg::REG_DESTINATION_ENCODING:
					destination_encoding_q <= pgmq_pkg::encoding_t'(cfg_data[0]);
				pgmq_pkg::REG_MATTE_RED:   matte_q[0] <= cfg_data;
				pgmq_pkg::REG_MATTE_GREEN: matte_q[1] <= cfg_data;
				pgmq_pkg::REG_MATTE_BLUE:  matte_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (source_encoding_q == destination_encoding_q) begin
			mode = pgmq_pkg::MODE_IDENTITY;
		end else if (source_encoding_q == pgmq_pkg::ENC_SRGB) begin
			mode = pgmq_pkg::MODE_SRGB_TO_BT2020;
		end else begin
			mode = pgmq_pkg::MODE_BT2020_TO_SRGB;
		end
	end

	// Unpack the beat and classify it; alpha above one takes priority.
	always_comb begin
		pixel_d.rgb[0] = s_axis_tdata[pgmq_pkg::SampleW-1:0];
		pixel_d.rgb[1] = s_axis_tdata[2*pgmq_pkg::SampleW-1:pgmq_pkg::SampleW];
		pixel_d.rgb[2] = s_axis_tdata[3*pgmq_pkg::SampleW-1:2*pgmq_pkg::SampleW];
		pixel_d.alpha  = s_axis_tdata[pgmq_pkg::InFieldsW-1:3*pgmq_pkg::SampleW];
		if (pixel_d.alpha > pgmq_pkg::AlphaW'(pgmq_pkg::AlphaOne)) begin
			pixel_d.status = pgmq_pkg::STATUS_ALPHA_HIGH;
		end else if (pixel_d.alpha == '0 && (pixel_d.rgb[0] != '0 || pixel_d.rgb[1] != '0
		                                     || pixel_d.rgb[2] != '0)) begin
			pixel_d.status = pgmq_pkg::STATUS_ZERO_ALPHA;
		end else begin
			pixel_d.status = pgmq_pkg::STATUS_OK;
		end
	end

	assign s_axis_tready = !valid_s1 || mult_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pixel_s1 <= pixel_d;
		end
	end

	pgmq_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (mult_ready),
		.in_pixel  (pixel_s1),
		.mode      (mode),
		.matte     (matte_q),
		.out_valid (mult_valid),
		.out_ready (quant_ready),
		.out_bus   (mult_bus)
	);

	pgmq_quant u_quant (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (mult_valid),
		.in_ready   (quant_ready),
		.in_bus     (mult_bus),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (result)
	);

	assign m_axis_tdata = {{(pgmq_pkg::OutDataW - pgmq_pkg::OutFieldsW){1'b0}},
	                       result.status, result.chan[2], result.chan[1], result.chan[0]};

endmodule
